@@ design/qssg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qssg_pkg
// Shared types and constants for the quadrature sine / sawtooth generator.
// ----------------------------------------------------------------------------
package qssg_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_INC,
    S_ACC,
    S_INIT,
    S_ROT,
    S_QUANT,
    S_MSIN,
    S_MCOS,
    S_MSAW,
    S_FIN
  } qssg_state_e;

  // Quadrant codes (top two bits of the turn)
  localparam logic [1:0] QuadFirst  = 2'd0;
  localparam logic [1:0] QuadSecond = 2'd1;
  localparam logic [1:0] QuadThird  = 2'd2;

  // Rotator datapath width, Q2.30 with headroom
  localparam int unsigned CordW = 34;

  // CORDIC start value K in Q2.30
  localparam logic signed [CordW-1:0] CordicK = 34'sd652032874;

  // atan(2^-i) in Q0.32 turns
  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] a;
    case (idx)
      5'd0:    a = 30'd536870912;
      5'd1:    a = 30'd316933406;
      5'd2:    a = 30'd167458907;
      5'd3:    a = 30'd85004756;
      5'd4:    a = 30'd42667331;
      5'd5:    a = 30'd21354465;
      5'd6:    a = 30'd10679838;
      5'd7:    a = 30'd5340245;
      5'd8:    a = 30'd2670163;
      5'd9:    a = 30'd1335087;
      5'd10:   a = 30'd667544;
      5'd11:   a = 30'd333772;
      5'd12:   a = 30'd166886;
      5'd13:   a = 30'd83443;
      5'd14:   a = 30'd41722;
      5'd15:   a = 30'd20861;
      5'd16:   a = 30'd10430;
      5'd17:   a = 30'd5215;
      5'd18:   a = 30'd2608;
      5'd19:   a = 30'd1304;
      5'd20:   a = 30'd652;
      5'd21:   a = 30'd326;
      5'd22:   a = 30'd163;
      5'd23:   a = 30'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Clamp a 34-bit signed sum to the signed 32-bit range
  function automatic logic signed [31:0] sat_q16(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ design/quadrature_sine_saw_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_sine_saw_generator_unit
// NCO with sine, cosine and sawtooth outputs, one result beat per tick beat.
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------------
//  cfg     | cfg_we_i (no wait)         | cfg_wdata_i = time_step, Q0.32
//  in      | in_valid_i / in_ready_o    | freq_i, amp_i, phase_offset_i, dc_offset_i
//  out     | out_valid_o / out_ready_i  | sin_out_o, cos_out_o, saw_out_o
//
//  From one acceptance to the next, an input beat takes the SINE_BITS CORDIC
//  rotations, one per cycle on the shift-add rotator, and nine other steps:
//  four on the one shared 33x33 multiplier (increment, sin, cos, saw), then
//  accumulate, rotator load, quantize, final load and the idle accept.
//  Reset puts time_step at 42950 and the phase accumulator at zero.
//  The output register holds a finished beat while the next input is
//  processed; only the final load waits on a stalled output.
//
// Flow: INC  multiply freq * time_step
//       ACC  add the increment to the accumulator (mod one turn)
//       INIT add phase offset, split quadrant, load the rotator
//       ROT  SINE_BITS rotations, z driven toward zero
//       QUANT round to Q1.SINE_BITS, clamp, fold in the quadrant
//       MSIN/MCOS/MSAW amplitude products, finished in MCOS, MSAW and FIN
//       FIN  round, add dc, saturate, load the output register
// ----------------------------------------------------------------------------
module quadrature_sine_saw_generator_unit #(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned SINE_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  // input beats
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] freq_i,
  input  logic signed [31:0] amp_i,
  input  logic [15:0]        phase_offset_i,
  input  logic signed [31:0] dc_offset_i,
  // result beats
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] sin_out_o,
  output logic signed [31:0] cos_out_o,
  output logic signed [31:0] saw_out_o
);
  import qssg_pkg::*;

  localparam int unsigned MulW   = 33;
  localparam int unsigned ProdW  = 2 * MulW;
  localparam int unsigned TrigW  = SINE_BITS + 2;
  localparam int unsigned IterW  = $clog2(SINE_BITS);
  localparam int unsigned IncLsb = 48 - PHASE_BITS;

  localparam logic [IterW-1:0] IterLast = IterW'(SINE_BITS - 1);
  // +-1.0 in Q1.SINE_BITS
  localparam logic signed [CordW-1:0] TrigOne  = CordW'(1) << SINE_BITS;
  localparam logic signed [TrigW-1:0] TrigMax  = TrigW'(TrigOne);
  // half LSB for the Q2.30 -> Q1.SINE_BITS rounding
  localparam logic signed [CordW-1:0] QuantRnd = CordW'(1) << (29 - SINE_BITS);
  // half LSB for amp * trig rounding back to Q16.16
  localparam logic signed [ProdW-1:0] TrigRnd  = ProdW'(1) << (SINE_BITS - 1);
  // half LSB for amp * Q0.32 turn
  localparam logic signed [ProdW-1:0] SawRnd   = ProdW'(1) << 31;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  qssg_state_e state_q, state_d;

  logic [31:0]            time_step_q;
  logic [PHASE_BITS-1:0]  phase_acc_q;

  logic signed [31:0]     freq_q;
  logic signed [31:0]     amp_q;
  logic [15:0]            poff_q;
  logic signed [31:0]     dc_q;

  logic signed [ProdW-1:0] prod_q;
  logic [31:0]             t32_q;
  logic [1:0]              quad_q;

  logic signed [CordW-1:0] x_q, y_q, z_q;
  logic [IterW-1:0]        iter_q;

  logic signed [TrigW-1:0] s_q, c_q;
  logic signed [31:0]      sin_stg_q, cos_stg_q;

  logic                    out_valid_q, out_valid_d;
  logic signed [31:0]      sin_out_q, cos_out_q, saw_out_q;

  // ---------------------------------------------------------------------------
  // Control outputs of the sequencer
  // ---------------------------------------------------------------------------
  logic                    in_ready;
  logic                    out_load;
  logic                    prod_load;
  logic signed [MulW-1:0]  mul_a, mul_b;

  // ---------------------------------------------------------------------------
  // Datapath combinational
  // ---------------------------------------------------------------------------
  logic signed [ProdW-1:0] mul_p;
  logic [PHASE_BITS-1:0]   inc;
  logic [PHASE_BITS-1:0]   tot;
  logic [31:0]             t32;

  logic signed [CordW-1:0] dx, dy, atan_e;
  logic                    rot_pos;

  logic signed [TrigW-1:0] sr, cr;
  logic signed [TrigW-1:0] s_d, c_d;

  logic signed [ProdW-1:0] trig_rnd, trig_sh, saw_rnd;
  logic signed [33:0]      dc_ext, trig_sum, saw_sum;
  logic signed [31:0]      trig_sat, saw_sat;

  // Shared multiplier
  assign mul_p = mul_a * mul_b;

  // Fraction of freq * time_step at the accumulator's resolution
  assign inc = prod_q[IncLsb +: PHASE_BITS];
  assign tot = phase_acc_q + (PHASE_BITS'(poff_q) << (PHASE_BITS - 16));

  // Total phase reduced to a 32-bit turn
  if (PHASE_BITS >= 32) begin : g_t32_hi
    assign t32 = tot[PHASE_BITS-1 -: 32];
  end else begin : g_t32_lo
    assign t32 = {tot, {(32 - PHASE_BITS){1'b0}}};
  end

  // Rotator step: arithmetic shifts floor toward minus infinity
  assign dx      = y_q >>> iter_q;
  assign dy      = x_q >>> iter_q;
  assign rot_pos = ~z_q[CordW-1];
  assign atan_e  = $signed({4'b0000, atan_turn(5'(iter_q))});

  function automatic logic signed [TrigW-1:0] quant(input logic signed [CordW-1:0] v);
    logic signed [CordW-1:0] r;
    r = (v + QuantRnd) >>> (30 - SINE_BITS);
    if (r > TrigOne) begin
      r = TrigOne;
    end else if (r < -TrigOne) begin
      r = -TrigOne;
    end
    return TrigW'(r);
  endfunction

  assign sr = quant(y_q);
  assign cr = quant(x_q);

  // Quadrant fold: exact swap and negate
  always_comb begin
    case (quad_q)
      QuadFirst: begin
        s_d = sr;
        c_d = cr;
      end
      QuadSecond: begin
        s_d = cr;
        c_d = -sr;
      end
      QuadThird: begin
        s_d = -sr;
        c_d = -cr;
      end
      default: begin
        s_d = -cr;
        c_d = sr;
      end
    endcase
  end

  // Finish a product: round, add dc, saturate
  assign dc_ext   = {{2{dc_q[31]}}, dc_q};
  assign trig_rnd = prod_q + TrigRnd;
  assign trig_sh  = trig_rnd >>> SINE_BITS;
  assign trig_sum = $signed(trig_sh[33:0]) + dc_ext;
  assign trig_sat = sat_q16(trig_sum);

  assign saw_rnd  = prod_q + SawRnd;
  assign saw_sum  = $signed(saw_rnd[65:32]) + dc_ext;
  assign saw_sat  = sat_q16(saw_sum);

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_INC;
      S_INC:   state_d = S_ACC;
      S_ACC:   state_d = S_INIT;
      S_INIT:  state_d = S_ROT;
      S_ROT:   if (iter_q == IterLast) state_d = S_QUANT;
      S_QUANT: state_d = S_MSIN;
      S_MSIN:  state_d = S_MCOS;
      S_MCOS:  state_d = S_MSAW;
      S_MSAW:  state_d = S_FIN;
      S_FIN:   if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    prod_load = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_INC: begin
        prod_load = 1'b1;
        mul_a     = {freq_q[31], freq_q};
        mul_b     = {1'b0, time_step_q};
      end
      S_MSIN: begin
        prod_load = 1'b1;
        mul_a     = {amp_q[31], amp_q};
        mul_b     = MulW'(s_q);
      end
      S_MCOS: begin
        prod_load = 1'b1;
        mul_a     = {amp_q[31], amp_q};
        mul_b     = MulW'(c_q);
      end
      S_MSAW: begin
        prod_load = 1'b1;
        mul_a     = {amp_q[31], amp_q};
        mul_b     = {1'b0, t32_q};
      end
      S_FIN: begin
        out_load = ~out_valid_q | out_ready_i;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      time_step_q <= 32'd42950;
      phase_acc_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        time_step_q <= cfg_wdata_i;
      end
      if (state_q == S_ACC) begin
        phase_acc_q <= phase_acc_q + inc;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      freq_q <= freq_i;
      amp_q  <= amp_i;
      poff_q <= phase_offset_i;
      dc_q   <= dc_offset_i;
    end
    if (prod_load) begin
      prod_q <= mul_p;
    end
    case (state_q)
      S_INIT: begin
        t32_q  <= t32;
        quad_q <= t32[31:30];
        x_q    <= CordicK;
        y_q    <= '0;
        z_q    <= $signed({4'b0000, t32[29:0]});
        iter_q <= '0;
      end
      S_ROT: begin
        x_q    <= rot_pos ? (x_q - dx) : (x_q + dx);
        y_q    <= rot_pos ? (y_q + dy) : (y_q - dy);
        z_q    <= rot_pos ? (z_q - atan_e) : (z_q + atan_e);
        iter_q <= iter_q + IterW'(1);
      end
      S_QUANT: begin
        s_q <= s_d;
        c_q <= c_d;
      end
      S_MCOS: begin
        sin_stg_q <= trig_sat;
      end
      S_MSAW: begin
        cos_stg_q <= trig_sat;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      sin_out_q <= sin_stg_q;
      cos_out_q <= cos_stg_q;
      saw_out_q <= saw_sat;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign sin_out_o   = sin_out_q;
  assign cos_out_o   = cos_out_q;
  assign saw_out_o   = saw_out_q;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_INC))
    else $error("accepted beat did not start the sequence");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROT) |-> (iter_q <= IterLast))
    else $error("rotation counter ran past its last step");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_ACC) |=> $stable(phase_acc_q))
    else $error("phase accumulator moved outside its update step");

  a_trig_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MSIN) |-> ((s_q <= TrigMax) && (s_q >= -TrigMax) &&
                             (c_q <= TrigMax) && (c_q >= -TrigMax)))
    else $error("sine or cosine outside +-1.0");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result beat raised outside the final step");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quadrature sine / sawtooth generator. Ticks go
// in over valid/ready, each one also steps an in-bench NCO model, and every
// result beat is compared field by field with the oldest predicted tone.
// ----------------------------------------------------------------------------
module tb_top;
  import qssg_pkg::*;

  // Nothing should stall longer than one tick plus a long run of receiver
  // stalls; a run of quiet cycles reaching StallLimit means the block is hung.
  localparam int StallLimit  = 2000;
  localparam int RandomTicks = 225;       // per phase, six phases
  localparam int MaxLogged   = 50;        // keep the log short on a bad build
  localparam longint CordStart = 652032874;  // CORDIC gain K, Q2.30
  localparam logic [31:0] StepAtReset = 32'd42950;

  typedef struct packed {
    logic signed [31:0] sin_v;
    logic signed [31:0] cos_v;
    logic signed [31:0] saw_v;
  } tone_t;

  // One stimulus row. When lit is set, want holds a hand-typed result that
  // replaces the model's answer; the model still steps so the phase tracks.
  typedef struct packed {
    logic signed [31:0] freq;
    logic signed [31:0] amp;
    logic [15:0]        poff;
    logic signed [31:0] dc;
    bit                 lit;
    tone_t              want;
  } tick_row_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [31:0]        cfg_wdata_i    = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] freq_i         = '0;
  logic signed [31:0] amp_i          = '0;
  logic [15:0]        phase_offset_i = '0;
  logic signed [31:0] dc_offset_i    = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic signed [31:0] sin_out_o;
  logic signed [31:0] cos_out_o;
  logic signed [31:0] saw_out_o;

  // Model state: the time step register and the phase accumulator.
  logic [31:0] step_len  = StepAtReset;
  logic [31:0] acc_phase = '0;

  tone_t     pending_tones[$];
  tick_row_t vectors[$];
  int        error_count = 0;
  int        beats_seen  = 0;
  int        quiet_cycles = 0;
  int        snd_idle    = 0;       // percent of cycles the sender holds off
  int        rcv_stall   = 0;       // percent of cycles the receiver stalls

  always #2 clk_i = ~clk_i;

  quadrature_sine_saw_generator_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .freq_i         (freq_i),
    .amp_i          (amp_i),
    .phase_offset_i (phase_offset_i),
    .dc_offset_i    (dc_offset_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sin_out_o      (sin_out_o),
    .cos_out_o      (cos_out_o),
    .saw_out_o      (saw_out_o)
  );

  // --------------------------------------------------------------------------
  // NCO model
  // --------------------------------------------------------------------------

  // atan(2^-i) in Q0.32 turns, first 16 rotations
  function automatic longint rot_angle(input int i);
    longint a;
    case (i)
      0:       a = 536870912;
      1:       a = 316933406;
      2:       a = 167458907;
      3:       a = 85004756;
      4:       a = 42667331;
      5:       a = 21354465;
      6:       a = 10679838;
      7:       a = 5340245;
      8:       a = 2670163;
      9:       a = 1335087;
      10:      a = 667544;
      11:      a = 333772;
      12:      a = 166886;
      13:      a = 83443;
      14:      a = 41722;
      default: a = 20861;
    endcase
    return a;
  endfunction

  // Q2.30 rotator output -> Q1.16, round half up, clamp to +-1.0
  function automatic longint round_unit(input longint v);
    longint r;
    r = (v + 64'sd8192) >>> 14;
    if (r > 64'sd65536) r = 64'sd65536;
    if (r < -64'sd65536) r = -64'sd65536;
    return r;
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Advances the accumulator by one tick and returns the tone it produces.
  function automatic tone_t compute_tones(input logic signed [31:0] f,
                                          input logic signed [31:0] a,
                                          input logic [15:0]        po,
                                          input logic signed [31:0] dc);
    logic [63:0] prod;
    logic [31:0] turn;
    longint      x, y, z, dx, dy, sr, cr, s, c, saw;
    tone_t       t;
    // freq is Q16.16 signed, step is Q0.32: the Q16.48 product's fraction,
    // floored to 32 bits, is the phase increment (two's complement wraps
    // negative frequencies back into [0,1) turns)
    prod      = {{32{f[31]}}, f} * {32'd0, step_len};
    acc_phase = acc_phase + prod[47:16];
    turn      = acc_phase + {po, 16'd0};

    x = CordStart;
    y = 0;
    z = longint'(turn[29:0]);
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - rot_angle(i);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + rot_angle(i);
      end
    end
    sr = round_unit(y);
    cr = round_unit(x);

    // fold the first-quadrant result out to the full turn
    case (turn[31:30])
      QuadFirst: begin
        s = sr;
        c = cr;
      end
      QuadSecond: begin
        s = cr;
        c = -sr;
      end
      QuadThird: begin
        s = -sr;
        c = -cr;
      end
      default: begin
        s = -cr;
        c = sr;
      end
    endcase

    t.sin_v = clip32(((longint'(a) * s + 64'sd32768) >>> 16) + longint'(dc));
    t.cos_v = clip32(((longint'(a) * c + 64'sd32768) >>> 16) + longint'(dc));
    // sawtooth: amp times the Q0.32 turn, rounded to Q16.16
    saw     = longint'(a) * longint'({32'd0, turn});
    saw     = (saw + 64'sd2147483648) >>> 32;
    t.saw_v = clip32(saw + longint'(dc));
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Error reporting
  // --------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    if (error_count < MaxLogged) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Drives one tick beat with random idle cycles ahead of it. Returns in the
  // step of the accepting edge, with valid still high; the next call (or a
  // caller) either keeps it high with new payload or lowers it, once.
  task automatic send_tick(input tick_row_t r);
    tone_t model;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    freq_i         <= r.freq;
    amp_i          <= r.amp;
    phase_offset_i <= r.poff;
    dc_offset_i    <= r.dc;
    do @(posedge clk_i); while (!in_ready_o);
    model = compute_tones(r.freq, r.amp, r.poff, r.dc);
    pending_tones.push_back(r.lit ? r.want : model);
  endtask

  // Writes time_step only once every tick has come back and the block has
  // settled into idle.
  task automatic set_step(input logic [31:0] v);
    in_valid_i <= 1'b0;
    while (pending_tones.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    step_len   = v;
  endtask

  task automatic add_row(input logic signed [31:0] f, input logic signed [31:0] a,
                         input logic [15:0] po, input logic signed [31:0] dc,
                         input bit lit, input logic signed [31:0] ws,
                         input logic signed [31:0] wc, input logic signed [31:0] wsw);
    tick_row_t r;
    r.freq = f;
    r.amp  = a;
    r.poff = po;
    r.dc   = dc;
    r.lit  = lit;
    r.want = '{sin_v: ws, cos_v: wc, saw_v: wsw};
    vectors.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: checks each accepted result beat, then picks the next
  // ready level. Everything is sampled at the edge, before the block's
  // registers move.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tone_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_seen++;
      if (pending_tones.size() == 0) begin
        flag_error($sformatf("result beat %0d with no tick outstanding", beats_seen));
      end else begin
        want = pending_tones.pop_front();
        if (sin_out_o !== want.sin_v)
          flag_error($sformatf("beat %0d sin_out %0d, want %0d",
                               beats_seen, sin_out_o, want.sin_v));
        if (cos_out_o !== want.cos_v)
          flag_error($sformatf("beat %0d cos_out %0d, want %0d",
                               beats_seen, cos_out_o, want.cos_v));
        if (saw_out_o !== want.saw_v)
          flag_error($sformatf("beat %0d saw_out %0d, want %0d",
                               beats_seen, saw_out_o, want.saw_v));
      end
    end
    out_ready_i <= rst_ni && ($urandom_range(0, 99) >= rcv_stall);
  end

  // Watchdog: any cycle with a beat on either channel resets the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("ERROR: no beat for %0d cycles", StallLimit);
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    tick_row_t r;
    logic [31:0] next_step;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks, run at the reset time step (42950).
    // Zero amplitude: every output is just the DC offset, so those rows
    // carry typed results, including the saturation rails.
    add_row(32'sd0, 32'sd0, 16'h0000, 32'sd0, 1'b1, 32'sd0, 32'sd0, 32'sd0);
    add_row(32'sd0, 32'sd0, 16'hffff, 32'sh7fff_ffff, 1'b1,
            32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    add_row(32'sd0, 32'sd0, 16'h8000, 32'sh8000_0000, 1'b1,
            32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    add_row(32'sd12345, 32'sd0, 16'h1234, -32'sd1, 1'b1, -32'sd1, -32'sd1, -32'sd1);
    // Unit amplitude around the four quadrants and the top of the turn
    add_row(32'sd0, 32'sh0001_0000, 16'h0000, 32'sd0, 1'b0, '0, '0, '0);
    add_row(32'sd0, 32'sh0001_0000, 16'h4000, 32'sd0, 1'b0, '0, '0, '0);
    add_row(32'sd0, 32'sh0001_0000, 16'h8000, 32'sd0, 1'b0, '0, '0, '0);
    add_row(32'sd0, 32'sh0001_0000, 16'hc000, 32'sd0, 1'b0, '0, '0, '0);
    add_row(32'sd0, 32'sh0001_0000, 16'hffff, 32'sd0, 1'b0, '0, '0, '0);
    // Frequency extremes; the negative ones must wrap into [0,1) turns
    add_row(32'sh7fff_ffff, 32'sh0001_0000, 16'h0000, 32'sd0, 1'b0, '0, '0, '0);
    add_row(32'sh8000_0000, 32'sh0001_0000, 16'h0000, 32'sd0, 1'b0, '0, '0, '0);
    add_row(-32'sh0001_0000, 32'sh0001_0000, 16'h0000, 32'sd0, 1'b0, '0, '0, '0);
    add_row(-32'sd1, 32'sh0001_0000, 16'h2000, 32'sd0, 1'b0, '0, '0, '0);
    add_row(-32'sh0004_0000, 32'sh0010_0000, 16'h0000, 32'sh0000_1234, 1'b0,
            '0, '0, '0);
    // Amplitude / offset extremes pushing the sums past both rails
    add_row(32'sd0, 32'sh7fff_ffff, 16'h2000, 32'sh7fff_ffff, 1'b0, '0, '0, '0);
    add_row(32'sd0, 32'sh8000_0000, 16'h2000, 32'sh8000_0000, 1'b0, '0, '0, '0);
    add_row(32'sd0, 32'sh7fff_ffff, 16'h6000, 32'sh8000_0000, 1'b0, '0, '0, '0);
    add_row(32'sd0, 32'sh8000_0000, 16'ha000, 32'sh7fff_ffff, 1'b0, '0, '0, '0);
    add_row(32'sh0001_0000, -32'sh0001_0000, 16'h1555, 32'sd0, 1'b0, '0, '0, '0);
    add_row(32'sh0001_0000, 32'sh0010_0000, 16'h0000, 32'sh0001_2345, 1'b0,
            '0, '0, '0);

    foreach (vectors[i]) send_tick(vectors[i]);

    // Random phases: each one sets a time step (extremes included) and an
    // idling pattern, then sends a batch of ticks.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin next_step = 32'hffff_ffff; snd_idle = 0;  rcv_stall = 0;  end
        1: begin next_step = 32'h0000_0000; snd_idle = 84; rcv_stall = 0;  end
        2: begin next_step = $urandom;      snd_idle = 0;  rcv_stall = 84; end
        3: begin next_step = 32'h0000_0001; snd_idle = 22; rcv_stall = 22; end
        4: begin next_step = 32'h0001_0000; snd_idle = 0;  rcv_stall = 0;  end
        default: begin next_step = $urandom; snd_idle = 22; rcv_stall = 22; end
      endcase
      set_step(next_step);

      for (int n = 0; n < RandomTicks; n++) begin
        // Arithmetic right shifts of a random word give every magnitude from
        // full scale down to 0 / -1, with both signs; small amplitudes and
        // offsets keep the trig outputs off the rails so rounding shows.
        r.freq = $signed($urandom) >>> $urandom_range(0, 31);
        r.amp  = $signed($urandom) >>> $urandom_range(0, 31);
        r.dc   = $signed($urandom) >>> $urandom_range(0, 31);
        case ($urandom_range(0, 7))
          0:       r.poff = 16'h0000;
          1:       r.poff = 16'hffff;
          default: r.poff = 16'($urandom_range(0, 65535));
        endcase
        r.lit  = 1'b0;
        r.want = '0;
        send_tick(r);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_tones.size() != 0) @(posedge clk_i);
    // let any stray beat show up before the verdict
    repeat (60) @(posedge clk_i);

    if (pending_tones.size() != 0)
      flag_error($sformatf("%0d ticks never produced a result", pending_tones.size()));

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ quadrature_sine_saw_generator_unit.f @@
design/qssg_pkg.sv
design/quadrature_sine_saw_generator_unit.sv
tb/tb_top.sv
